[hdl/hsp_pkg.sv]
// ----------------------------------------------------------------------------
// hsp_pkg
// Shared types, codes and the half-step coil table for the stepper sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package hsp_pkg;

    // Width of the position and target registers.
    localparam int POS_WIDTH = 32;

    localparam int ACTION_W = 2;
    localparam int MODE_W   = 3;
    localparam int TARGET_W = 32;
    localparam int PHASE_W  = 3;
    localparam int DIR_W    = 2;
    localparam int COIL_W   = 4;
    localparam int OUTPOS_W = 32;
    localparam int TICK_W   = 32;

    // Stream word widths, padded to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 80;

    localparam logic [ACTION_W-1:0] ACT_TICK       = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SET_MODE   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SET_TARGET = 2'd2;

    localparam logic [MODE_W-1:0] MODE_IDLE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POS  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FWD  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BWD  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_HOME = 3'd4;

    localparam logic [DIR_W-1:0] DIR_STOP = 2'b00;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'b01;
    localparam logic [DIR_W-1:0] DIR_BWD  = 2'b11;

    localparam logic [COIL_W-1:0] COIL_TABLE [8] = '{
        4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hc, 4'h8, 4'h9
    };

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [MODE_W-1:0]   new_mode;
        logic [TARGET_W-1:0] target_position;
        logic                ref_switch;
    } t_item;

    typedef struct packed {
        logic [COIL_W-1:0]   coil_pattern;
        logic [OUTPOS_W-1:0] position;
        logic [DIR_W-1:0]    direction;
        logic [MODE_W-1:0]   mode;
        logic [TICK_W-1:0]   tick_count;
    } t_result;

    // Sign-extend or truncate the 32-bit target to the position width.
    function automatic logic [POS_WIDTH-1:0] target_to_pos(input logic [TARGET_W-1:0] t);
        logic signed [63:0] w;
        w = 64'(signed'(t));
        return w[POS_WIDTH-1:0];
    endfunction

    // Sign-extend or truncate the position register to the 32-bit output.
    function automatic logic [OUTPOS_W-1:0] pos_to_out(input logic [POS_WIDTH-1:0] p);
        logic signed [63:0] w;
        w = 64'(signed'(p));
        return w[OUTPOS_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hdl/stepper_half_step_position_controller.sv]
// ----------------------------------------------------------------------------
// stepper_half_step_position_controller
// Half-step sequencer for a unipolar stepper with position, free-run and
// homing modes.
// ----------------------------------------------------------------------------
// Usage: every word on the slave stream is either a tick (tuser = 0), a mode
// command (tuser = 1) or a target command (tuser = 2); tuser = 3 changes
// nothing. Each accepted word gives exactly one result word on the master
// stream carrying the coil pattern, position, last direction, mode and the
// tick count after that word.
// An accepted input word passes through the input register, then the
// sequencer state registers, which also hold the result. Throughput is one
// word per cycle while the receiver keeps tready high; the whole update is a
// signed compare and a position add feeding the state registers.
// A synchronous active-low reset clears the mode to idle, position, target,
// phase, direction and tick count to zero; coil pattern then reads 0x1.
// When the receiver holds tready low the result word stays put, the input
// register fills, and then s_axis tready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_half_step_position_controller (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // new_mode[2:0], target_position[34:3], ref_switch[35], zero fill above
    input  wire logic [hsp_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // action[1:0]
    input  wire logic [hsp_pkg::ACTION_W-1:0]    i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // coil_pattern[3:0], position[35:4], direction[37:36], mode[40:38],
    // tick_count[72:41], zero fill above
    output logic [hsp_pkg::M_TDATA_W-1:0]        o_m_axis_tdata
);

    hsp_pkg::t_item   in_item;
    hsp_pkg::t_item   core_item;
    hsp_pkg::t_result core_result;
    logic             core_valid;
    logic             core_ready;

    assign in_item.action          = i_s_axis_tuser;
    assign in_item.new_mode        = i_s_axis_tdata[2:0];
    assign in_item.target_position = i_s_axis_tdata[34:3];
    assign in_item.ref_switch      = i_s_axis_tdata[35];

    hsp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (in_item),
        .o_valid (core_valid),
        .i_ready (core_ready),
        .o_item  (core_item)
    );

    hsp_seq_core u_seq_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (core_valid),
        .o_ready  (core_ready),
        .i_item   (core_item),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (core_result)
    );

    assign o_m_axis_tdata = {
        7'd0,
        core_result.tick_count,
        core_result.mode,
        core_result.direction,
        core_result.position,
        core_result.coil_pattern
    };

endmodule

`default_nettype wire

[hdl/hsp_in_stage.sv]
// ----------------------------------------------------------------------------
// hsp_in_stage
// Input register slice: captures one word and holds it until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hsp_in_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire hsp_pkg::t_item i_item,
    output logic                o_valid,
    input  wire logic           i_ready,
    output hsp_pkg::t_item      o_item
);

    logic           r_valid;
    hsp_pkg::t_item r_item;

    // The slot frees up in the same cycle the core takes its word.
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

[hdl/hsp_seq_core.sv]
// ----------------------------------------------------------------------------
// hsp_seq_core
// Sequencer state, next-state logic and the registered result word.
// ----------------------------------------------------------------------------
`default_nettype none

module hsp_seq_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire hsp_pkg::t_item i_item,
    output logic                o_valid,
    input  wire logic           i_ready,
    output hsp_pkg::t_result    o_result
);

    logic                                r_res_valid;
    logic [hsp_pkg::MODE_W-1:0]          r_mode;
    logic [hsp_pkg::POS_WIDTH-1:0]       r_target;
    logic [hsp_pkg::POS_WIDTH-1:0]       r_pos;
    logic [hsp_pkg::PHASE_W-1:0]         r_phase;
    logic [hsp_pkg::DIR_W-1:0]           r_dir;
    logic [hsp_pkg::TICK_W-1:0]          r_tick;
    logic [hsp_pkg::COIL_W-1:0]          r_coil;

    logic [hsp_pkg::MODE_W-1:0]          n_mode;
    logic [hsp_pkg::POS_WIDTH-1:0]       n_target;
    logic [hsp_pkg::POS_WIDTH-1:0]       n_pos;
    logic [hsp_pkg::PHASE_W-1:0]         n_phase;
    logic [hsp_pkg::DIR_W-1:0]           n_dir;
    logic [hsp_pkg::TICK_W-1:0]          n_tick;
    logic [hsp_pkg::DIR_W-1:0]           tick_dir;
    logic [hsp_pkg::POS_WIDTH-1:0]       tick_base;
    logic                                take;

    assign o_ready = !r_res_valid || i_ready;
    assign take    = i_valid && o_ready;

    // Direction chosen by the mode on a tick.
    always_comb begin
        unique case (r_mode)
            hsp_pkg::MODE_POS: begin
                if ($signed(r_target) > $signed(r_pos)) begin
                    tick_dir = hsp_pkg::DIR_FWD;
                end else if ($signed(r_target) < $signed(r_pos)) begin
                    tick_dir = hsp_pkg::DIR_BWD;
                end else begin
                    tick_dir = hsp_pkg::DIR_STOP;
                end
            end
            hsp_pkg::MODE_FWD:  tick_dir = hsp_pkg::DIR_FWD;
            hsp_pkg::MODE_BWD:  tick_dir = hsp_pkg::DIR_BWD;
            hsp_pkg::MODE_HOME: tick_dir = i_item.ref_switch ? hsp_pkg::DIR_BWD
                                                             : hsp_pkg::DIR_STOP;
            default:            tick_dir = hsp_pkg::DIR_STOP;
        endcase
    end

    // Reaching the reference while homing zeroes the position before the step.
    assign tick_base = (r_mode == hsp_pkg::MODE_HOME && !i_item.ref_switch)
                     ? '0 : r_pos;

    always_comb begin
        n_mode   = r_mode;
        n_target = r_target;
        n_pos    = r_pos;
        n_phase  = r_phase;
        n_dir    = r_dir;
        n_tick   = r_tick;
        unique case (i_item.action)
            hsp_pkg::ACT_TICK: begin
                n_tick  = r_tick + 1'b1;
                n_dir   = tick_dir;
                n_phase = r_phase + {tick_dir[1], tick_dir};
                n_pos   = tick_base
                        + {{(hsp_pkg::POS_WIDTH-hsp_pkg::DIR_W){tick_dir[1]}}, tick_dir};
                if (r_mode == hsp_pkg::MODE_HOME && !i_item.ref_switch) begin
                    n_mode = hsp_pkg::MODE_IDLE;
                end
            end
            hsp_pkg::ACT_SET_MODE: begin
                if (i_item.new_mode <= hsp_pkg::MODE_HOME) begin
                    n_mode = i_item.new_mode;
                end
            end
            hsp_pkg::ACT_SET_TARGET: begin
                n_target = hsp_pkg::target_to_pos(i_item.target_position);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
            r_mode      <= hsp_pkg::MODE_IDLE;
            r_target    <= '0;
            r_pos       <= '0;
            r_phase     <= '0;
            r_dir       <= hsp_pkg::DIR_STOP;
            r_tick      <= '0;
            r_coil      <= hsp_pkg::COIL_TABLE[0];
        end else begin
            if (take) begin
                r_res_valid <= 1'b1;
                r_mode      <= n_mode;
                r_target    <= n_target;
                r_pos       <= n_pos;
                r_phase     <= n_phase;
                r_dir       <= n_dir;
                r_tick      <= n_tick;
                r_coil      <= hsp_pkg::COIL_TABLE[n_phase];
            end else if (i_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // The state registers double as the result register: a new word is only
    // taken when no result is held or the previous one leaves in the same cycle.
    assign o_valid               = r_res_valid;
    assign o_result.coil_pattern = r_coil;
    assign o_result.position     = hsp_pkg::pos_to_out(r_pos);
    assign o_result.direction    = r_dir;
    assign o_result.mode         = r_mode;
    assign o_result.tick_count   = r_tick;

    a_tick_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_item.action == hsp_pkg::ACT_TICK |=> r_tick == $past(r_tick) + 1'b1)
        else $error("tick counter did not advance on a tick");

    a_cmd_no_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_item.action != hsp_pkg::ACT_TICK
        |=> r_pos == $past(r_pos) && r_phase == $past(r_phase) && r_tick == $past(r_tick))
        else $error("command word moved the motor");

    a_home_reached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_item.action == hsp_pkg::ACT_TICK && r_mode == hsp_pkg::MODE_HOME
        && !i_item.ref_switch
        |=> r_pos == '0 && r_mode == hsp_pkg::MODE_IDLE && r_dir == hsp_pkg::DIR_STOP)
        else $error("homing did not settle at the reference");

    a_dir_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dir != 2'b10)
        else $error("direction register holds an illegal step");

    a_coil_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> r_coil == hsp_pkg::COIL_TABLE[r_phase])
        else $error("coil pattern does not match the phase");

endmodule

`default_nettype wire
